>>> hdl/cwg_pkg.sv
// ----------------------------------------------------------------------------
// cwg_pkg
// Shared types and constants of the cosine window coefficient generator.
// ----------------------------------------------------------------------------
package cwg_pkg;

  typedef enum logic [1:0] {
    KIND_HANN     = 2'd0,
    KIND_HAMMING  = 2'd1,
    KIND_BLACKMAN = 2'd2
  } kind_e;

  typedef enum logic [1:0] {
    REG_KIND     = 2'd0,
    REG_LENGTH   = 2'd1,
    REG_PERIODIC = 2'd2
  } reg_idx_e;

  // side-band of one word as it travels down the pipeline
  typedef struct packed {
    logic        in_range;
    logic        len_one;
    logic [15:0] echo;
  } ctl_t;

  localparam logic [29:0] C_HALF = 30'd536870912;
  localparam logic [29:0] C_054  = 30'd579820585;
  localparam logic [29:0] C_046  = 30'd493921239;
  localparam logic [29:0] C_042  = 30'd450971566;
  localparam logic [29:0] C_008  = 30'd85899346;

  localparam longint unsigned PI_Q30 = 64'd3373259426;

  localparam longint unsigned TAYLOR_DIV [8] = '{
    64'd2, 64'd12, 64'd30, 64'd56, 64'd90, 64'd132, 64'd182, 64'd240
  };

endpackage

>>> hdl/cosine_window_coefficient_generator.sv
// start_i is registered, then passes the divider, cwg_cos and cwg_mix stages to valid_o.
// Throughput: one word per cycle; busy_o stays low, the phase divider is
// pipelined one quotient bit per stage.
// Reset: Hann, length 8, symmetric; pipeline valid bits cleared.
// The receiver cannot stall: each result shows for one cycle with valid_o.
// ----------------------------------------------------------------------------
// cosine_window_coefficient_generator
// Hann, Hamming or Blackman window coefficient for each requested index.
// ----------------------------------------------------------------------------
module cosine_window_coefficient_generator
  import cwg_pkg::*;
#(
  parameter int LENGTH_BITS         = 16,
  parameter int PHASE_BITS          = 16,
  parameter int QUARTER_TABLE_DEPTH = 1024,
  parameter int FRACTION_BITS       = 15
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_idx_i,
  input  logic [15:0] cfg_data_i,
  input  logic        start_i,
  output logic        busy_o,
  input  logic [15:0] sample_index_i,
  output logic        valid_o,
  output logic [15:0] coefficient_o,
  output logic [15:0] echo_index_o,
  output logic        in_range_o
);

  localparam int NB = (LENGTH_BITS < 16) ? LENGTH_BITS : 16;

  logic [1:0]    kind_q;
  logic [15:0]   length_q;
  logic          periodic_q;

  logic [NB-1:0] len, n, m;
  logic          vld0_q;
  logic [NB-1:0] n0_q;
  ctl_t          ctl0_q;

  logic                  div_vld;
  logic [PHASE_BITS-1:0] phase;
  ctl_t                  div_ctl;

  logic        cos_vld, neg1, neg2;
  logic [30:0] mag1, mag2;
  ctl_t        cos_ctl;

  assign busy_o = 1'b0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      kind_q     <= KIND_HANN;
      length_q   <= 16'd8;
      periodic_q <= 1'b0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_KIND:     kind_q     <= cfg_data_i[1:0];
        REG_LENGTH:   length_q   <= cfg_data_i;
        REG_PERIODIC: periodic_q <= cfg_data_i[0];
        default:      ;
      endcase
    end
  end

  always_comb begin
    len = length_q[NB-1:0];
    n   = sample_index_i[NB-1:0];
    m   = periodic_q ? len : len - NB'(1);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld0_q <= 1'b0;
    end else begin
      vld0_q <= start_i && !busy_o;
    end
  end

  always_ff @(posedge clk_i) begin
    n0_q            <= n;
    ctl0_q.in_range <= (n < len);
    ctl0_q.len_one  <= (len == NB'(1));
    ctl0_q.echo     <= sample_index_i;
  end

  cwg_div #(
    .N_BITS     (NB),
    .PHASE_BITS (PHASE_BITS)
  ) u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (vld0_q),
    .n_i     (n0_q),
    .m_i     (m),
    .ctl_i   (ctl0_q),
    .valid_o (div_vld),
    .phase_o (phase),
    .ctl_o   (div_ctl)
  );

  cwg_cos #(
    .PHASE_BITS          (PHASE_BITS),
    .QUARTER_TABLE_DEPTH (QUARTER_TABLE_DEPTH)
  ) u_cos (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (div_vld),
    .phase_i (phase),
    .ctl_i   (div_ctl),
    .valid_o (cos_vld),
    .mag1_o  (mag1),
    .neg1_o  (neg1),
    .mag2_o  (mag2),
    .neg2_o  (neg2),
    .ctl_o   (cos_ctl)
  );

  cwg_mix #(
    .FRACTION_BITS (FRACTION_BITS)
  ) u_mix (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .kind_i        (kind_q),
    .valid_i       (cos_vld),
    .mag1_i        (mag1),
    .neg1_i        (neg1),
    .mag2_i        (mag2),
    .neg2_i        (neg2),
    .ctl_i         (cos_ctl),
    .valid_o       (valid_o),
    .coefficient_o (coefficient_o),
    .echo_index_o  (echo_index_o),
    .in_range_o    (in_range_o)
  );

endmodule

>>> hdl/cwg_div.sv
// ----------------------------------------------------------------------------
// cwg_div
// Pipelined restoring divider giving the rounded phase n * 2^PB / m,
// one quotient bit per stage.
// ----------------------------------------------------------------------------
module cwg_div
  import cwg_pkg::*;
#(
  parameter int N_BITS     = 16,
  parameter int PHASE_BITS = 16
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  valid_i,
  input  logic [N_BITS-1:0]     n_i,
  input  logic [N_BITS-1:0]     m_i,
  input  ctl_t                  ctl_i,
  output logic                  valid_o,
  output logic [PHASE_BITS-1:0] phase_o,
  output ctl_t                  ctl_o
);

  localparam int W     = N_BITS + PHASE_BITS + 1;
  localparam int STEPS = PHASE_BITS + 1;

  logic [W-1:0] word_d [STEPS+1];
  logic [W-1:0] word_q [STEPS+1];
  logic         vld_q  [STEPS+1];
  ctl_t         ctl_q  [STEPS+1];

  // dividend: n shifted up plus half the divisor for rounding
  assign word_q[0] = ({{(PHASE_BITS+1){1'b0}}, n_i} << PHASE_BITS)
                   + W'(m_i >> 1);
  assign vld_q[0]  = valid_i;
  assign ctl_q[0]  = ctl_i;
  assign word_d[0] = word_q[0];

  for (genvar k = 1; k <= STEPS; k++) begin : g_step
    logic [W:0]        sh;
    logic [N_BITS:0]   top;
    logic [N_BITS:0]   diff;
    logic              qb;

    always_comb begin
      sh   = {word_q[k-1], 1'b0};
      top  = sh[W:PHASE_BITS+1];
      diff = top - {1'b0, m_i};
      qb   = (top >= {1'b0, m_i});
      word_d[k] = qb ? {diff[N_BITS-1:0], sh[PHASE_BITS:1], 1'b1}
                     : {top[N_BITS-1:0], sh[PHASE_BITS:1], 1'b0};
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[k] <= 1'b0;
      end else begin
        vld_q[k] <= vld_q[k-1];
      end
    end

    always_ff @(posedge clk_i) begin
      word_q[k] <= word_d[k];
      ctl_q[k]  <= ctl_q[k-1];
    end
  end

  assign valid_o = vld_q[STEPS];
  assign phase_o = word_q[STEPS][PHASE_BITS-1:0];
  assign ctl_o   = ctl_q[STEPS];

endmodule

>>> hdl/cwg_cos.sv
// ----------------------------------------------------------------------------
// cwg_cos
// Quadrant folding and quarter-wave cosine table lookup for the phase
// and the doubled phase.
// ----------------------------------------------------------------------------
module cwg_cos
  import cwg_pkg::*;
#(
  parameter int PHASE_BITS          = 16,
  parameter int QUARTER_TABLE_DEPTH = 1024
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  valid_i,
  input  logic [PHASE_BITS-1:0] phase_i,
  input  ctl_t                  ctl_i,
  output logic                  valid_o,
  output logic [30:0]           mag1_o,
  output logic                  neg1_o,
  output logic [30:0]           mag2_o,
  output logic                  neg2_o,
  output ctl_t                  ctl_o
);

  localparam int IW    = $clog2(QUARTER_TABLE_DEPTH + 1);
  localparam int RW    = PHASE_BITS - 2;
  localparam int PW    = RW + IW + 1;
  localparam int TWO_D = 2 * QUARTER_TABLE_DEPTH;
  localparam logic [PW-1:0] HALF  = PW'(1) << (PHASE_BITS - 3);
  localparam logic [IW-1:0] DEPTH = IW'(QUARTER_TABLE_DEPTH);

  typedef logic [30:0] rom_t [QUARTER_TABLE_DEPTH+1];

  function automatic rom_t build_rom();
    rom_t            t;
    longint unsigned x;
    longint unsigned x2;
    longint unsigned term;
    longint          sum;
    for (int k = 0; k <= QUARTER_TABLE_DEPTH; k++) begin
      x    = (PI_Q30 * longint'(k) + longint'(QUARTER_TABLE_DEPTH)) / TWO_D;
      x2   = (x * x + (64'd1 << 29)) >> 30;
      term = 64'd1 << 30;
      sum  = 64'sd1 << 30;
      for (int j = 0; j < 8; j++) begin
        term = ((term * x2 + (64'd1 << 29)) >> 30) / TAYLOR_DIV[j];
        if (j % 2 == 0) begin
          sum = sum - longint'(term);
        end else begin
          sum = sum + longint'(term);
        end
      end
      if (sum < 0) sum = 0;
      if (sum > (64'sd1 << 30)) sum = 64'sd1 << 30;
      t[k] = 31'(sum);
    end
    return t;
  endfunction

  localparam rom_t ROM = build_rom();

  function automatic logic [IW-1:0] fold_index(logic [RW-1:0] r);
    logic [PW-1:0] prod;
    logic [PW-1:0] idx;
    prod = PW'(r) * PW'(QUARTER_TABLE_DEPTH) + HALF;
    idx  = prod >> RW;
    if (idx > PW'(QUARTER_TABLE_DEPTH)) idx = PW'(QUARTER_TABLE_DEPTH);
    return idx[IW-1:0];
  endfunction

  logic [PHASE_BITS-1:0] p2;
  logic [IW-1:0]         i1, i2;
  logic [IW-1:0]         addr1_q, addr2_q;
  logic                  neg1_q, neg2_q, neg1_r, neg2_r;
  logic                  vld1_q, vld2_q;
  ctl_t                  ctl1_q, ctl2_q;
  logic [30:0]           mag1_q, mag2_q;

  always_comb begin
    p2 = {phase_i[PHASE_BITS-2:0], 1'b0};
    i1 = fold_index(phase_i[RW-1:0]);
    i2 = fold_index(p2[RW-1:0]);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld1_q <= 1'b0;
      vld2_q <= 1'b0;
    end else begin
      vld1_q <= valid_i;
      vld2_q <= vld1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    addr1_q <= phase_i[PHASE_BITS-2] ? DEPTH - i1 : i1;
    addr2_q <= p2[PHASE_BITS-2] ? DEPTH - i2 : i2;
    neg1_q  <= phase_i[PHASE_BITS-1] ^ phase_i[PHASE_BITS-2];
    neg2_q  <= p2[PHASE_BITS-1] ^ p2[PHASE_BITS-2];
    ctl1_q  <= ctl_i;
    mag1_q  <= ROM[addr1_q];
    mag2_q  <= ROM[addr2_q];
    neg1_r  <= neg1_q;
    neg2_r  <= neg2_q;
    ctl2_q  <= ctl1_q;
  end

  assign valid_o = vld2_q;
  assign mag1_o  = mag1_q;
  assign neg1_o  = neg1_r;
  assign mag2_o  = mag2_q;
  assign neg2_o  = neg2_r;
  assign ctl_o   = ctl2_q;

endmodule

>>> hdl/cwg_mix.sv
// ----------------------------------------------------------------------------
// cwg_mix
// Weights the cosines by the window coefficients, sums, clamps and rounds
// to the output format; holds the output register.
// ----------------------------------------------------------------------------
module cwg_mix
  import cwg_pkg::*;
#(
  parameter int FRACTION_BITS = 15
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic [1:0]  kind_i,
  input  logic        valid_i,
  input  logic [30:0] mag1_i,
  input  logic        neg1_i,
  input  logic [30:0] mag2_i,
  input  logic        neg2_i,
  input  ctl_t        ctl_i,
  output logic        valid_o,
  output logic [15:0] coefficient_o,
  output logic [15:0] echo_index_o,
  output logic        in_range_o
);

  localparam int SH = 30 - FRACTION_BITS;
  localparam logic [31:0] RND = (32'd1 << SH) >> 1;
  localparam logic [31:0] ONE = 32'd1 << FRACTION_BITS;

  logic [29:0] a0, a1, a2;
  logic [60:0] prod1, prod2;
  logic [60:0] rnd1, rnd2;

  logic        vld1_q, vld2_q;
  logic [30:0] t1_q, t2_q;
  logic        neg1_q, neg2_q;
  logic [29:0] a0_q;
  ctl_t        ctl1_q;

  logic signed [33:0] v;
  logic [31:0]        vc;
  logic [31:0]        coef;
  logic [31:0]        res;

  logic [15:0] coef_q, echo_q;
  logic        rng_q;

  always_comb begin
    case (kind_i)
      KIND_HAMMING: begin
        a0 = C_054;
        a1 = C_046;
        a2 = '0;
      end
      KIND_BLACKMAN: begin
        a0 = C_042;
        a1 = C_HALF;
        a2 = C_008;
      end
      default: begin
        a0 = C_HALF;
        a1 = C_HALF;
        a2 = '0;
      end
    endcase
    prod1 = 61'(a1) * 61'(mag1_i);
    prod2 = 61'(a2) * 61'(mag2_i);
    rnd1  = (prod1 + (61'd1 << 29)) >> 30;
    rnd2  = (prod2 + (61'd1 << 29)) >> 30;
  end

  always_comb begin
    v = $signed({4'b0, a0_q});
    v = neg1_q ? v + $signed({3'b0, t1_q}) : v - $signed({3'b0, t1_q});
    v = neg2_q ? v - $signed({3'b0, t2_q}) : v + $signed({3'b0, t2_q});
    if (v < 0) begin
      vc = '0;
    end else if (v > 34'sd1073741824) begin
      vc = 32'd1073741824;
    end else begin
      vc = v[31:0];
    end
    coef = (vc + RND) >> SH;
    if (coef > ONE) coef = ONE;
    if (!ctl1_q.in_range) begin
      res = '0;
    end else if (ctl1_q.len_one) begin
      res = ONE;
    end else begin
      res = coef;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld1_q <= 1'b0;
      vld2_q <= 1'b0;
    end else begin
      vld1_q <= valid_i;
      vld2_q <= vld1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    t1_q   <= rnd1[30:0];
    t2_q   <= rnd2[30:0];
    neg1_q <= neg1_i;
    neg2_q <= neg2_i;
    a0_q   <= a0;
    ctl1_q <= ctl_i;
    coef_q <= res[15:0];
    echo_q <= ctl1_q.echo;
    rng_q  <= ctl1_q.in_range;
  end

  assign valid_o       = vld2_q;
  assign coefficient_o = coef_q;
  assign echo_index_o  = echo_q;
  assign in_range_o    = rng_q;

endmodule

>>> tb/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Checks the window coefficient generator against an in-bench predictor:
// directed corner words, then 8 random settings and indices with random start
// gaps in the first 6; each result word is compared with the oldest expected.
// ----------------------------------------------------------------------------
module tb;
  import cwg_pkg::*;

  localparam int QDEPTH    = 1024;
  localparam int LATENCY   = 22;
  localparam int WD_LIMIT  = 2000;
  localparam int NO_VALUE  = -1;

  typedef enum logic { ROW_SAMPLE, ROW_WRITE } row_e;

  typedef struct {
    row_e        kind;
    reg_idx_e    reg_sel;
    logic [15:0] value;
    int          want_coef;
  } row_t;

  typedef struct {
    logic [15:0] coef;
    logic [15:0] echo;
    logic        in_range;
  } coef_word_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_we_i = 1'b0;
  logic [1:0]  cfg_idx_i = '0;
  logic [15:0] cfg_data_i = '0;
  logic        start_i = 1'b0;
  logic        busy_o;
  logic [15:0] sample_index_i = '0;
  logic        valid_o;
  logic [15:0] coefficient_o;
  logic [15:0] echo_index_o;
  logic        in_range_o;

  cosine_window_coefficient_generator dut (.*);

  always #2 clk_i = ~clk_i;

  longint      cos_quarter [0:QDEPTH];
  logic [1:0]  kind_q = KIND_HANN;
  logic [15:0] length_q = 16'd8;
  logic        periodic_q = 1'b0;
  coef_word_t  pending_q [$];
  int          forced_coef = NO_VALUE;
  int          words_taken = 0;
  int          words_seen = 0;
  int          errors = 0;
  int          idle_run = 0;
  bit          gaps_on = 1'b0;

  task automatic report(input string what, input longint got, input longint want);
    $display("mismatch %s: got %0d want %0d (result %0d)", what, got, want, words_seen);
    errors++;
  endtask

  function automatic longint cos_of_phase(input longint unsigned p);
    longint unsigned r, i;
    logic [1:0] q;
    p = p & 64'hFFFF;
    q = p[15:14];
    r = p & 64'h3FFF;
    i = (r * QDEPTH + 64'd8192) >> 14;
    if (i > QDEPTH) i = QDEPTH;
    case (q)
      2'd0: return cos_quarter[i];
      2'd1: return -cos_quarter[QDEPTH - i];
      2'd2: return -cos_quarter[i];
      default: return cos_quarter[QDEPTH - i];
    endcase
  endfunction

  function automatic longint mul_q30(input longint unsigned a, input longint c);
    longint unsigned mag;
    longint v;
    mag = (c < 0) ? longint'(-c) : c;
    v = longint'((a * mag + (64'd1 << 29)) >> 30);
    return (c < 0) ? -v : v;
  endfunction

  function automatic coef_word_t window_value(input logic [15:0] n);
    coef_word_t w;
    longint unsigned m, p, a0, a1, a2, c;
    longint v;
    w.echo = n;
    w.coef = '0;
    w.in_range = 1'b0;
    if (n < length_q) begin
      w.in_range = 1'b1;
      if (length_q == 16'd1) begin
        w.coef = 16'd32768;
      end else begin
        m = periodic_q ? length_q : length_q - 1;
        p = ((longint'(n) << 16) + (m >> 1)) / m;
        a0 = C_HALF; a1 = C_HALF; a2 = 0;
        if (kind_q == KIND_HAMMING) begin
          a0 = C_054; a1 = C_046;
        end else if (kind_q == KIND_BLACKMAN) begin
          a0 = C_042; a2 = C_008;
        end
        v = longint'(a0) - mul_q30(a1, cos_of_phase(p));
        if (a2 != 0) v += mul_q30(a2, cos_of_phase(p << 1));
        if (v < 0) v = 0;
        if (v > (64'd1 << 30)) v = 64'd1 << 30;
        c = (longint'(v) + 64'd16384) >> 15;
        if (c > 32768) c = 32768;
        w.coef = c[15:0];
      end
    end
    return w;
  endfunction

  initial begin
    longint unsigned x, x2, term;
    longint sum;
    for (int k = 0; k <= QDEPTH; k++) begin
      x = (PI_Q30 * k + QDEPTH) / (2 * QDEPTH);
      x2 = (x * x + (64'd1 << 29)) >> 30;
      term = 64'd1 << 30;
      sum = 64'd1 << 30;
      for (int j = 1; j <= 8; j++) begin
        term = ((term * x2 + (64'd1 << 29)) >> 30) / TAYLOR_DIV[j - 1];
        if (j % 2) sum -= longint'(term);
        else sum += longint'(term);
      end
      if (sum < 0) sum = 0;
      if (sum > (64'd1 << 30)) sum = 64'd1 << 30;
      cos_quarter[k] = sum;
    end
  end

  always @(posedge clk_i) begin
    coef_word_t w, e;
    if (rst_ni) begin
      if (cfg_we_i) begin
        case (reg_idx_e'(cfg_idx_i))
          REG_KIND:     kind_q <= cfg_data_i[1:0];
          REG_LENGTH:   length_q <= cfg_data_i;
          REG_PERIODIC: periodic_q <= cfg_data_i[0];
          default: ;
        endcase
      end
      if (start_i && !busy_o) begin
        w = window_value(sample_index_i);
        if (forced_coef != NO_VALUE) w.coef = forced_coef[15:0];
        pending_q.push_back(w);
        words_taken <= words_taken + 1;
      end
      if (valid_o) begin
        words_seen++;
        if (pending_q.size() == 0) begin
          report("unexpected word echo", echo_index_o, 0);
        end else begin
          e = pending_q.pop_front();
          if (coefficient_o !== e.coef) report("coefficient", coefficient_o, e.coef);
          if (echo_index_o !== e.echo) report("echo_index", echo_index_o, e.echo);
          if (in_range_o !== e.in_range) report("in_range", in_range_o, e.in_range);
        end
      end
      if ((start_i && !busy_o) || valid_o) idle_run <= 0;
      else idle_run <= idle_run + 1;
      if (idle_run >= WD_LIMIT) begin
        $display("timeout after %0d idle cycles", idle_run);
        $display("== FAIL ==");
        $finish;
      end
    end
  end

  task automatic send_index(input logic [15:0] n);
    int target;
    if (gaps_on && $urandom_range(0, 3) == 0) begin
      start_i <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk_i);
    end
    target = words_taken + 1;
    start_i <= 1'b1;
    sample_index_i <= n;
    wait (words_taken == target);
  endtask

  task automatic settle();
    start_i <= 1'b0;
    while (pending_q.size() != 0) @(posedge clk_i);
    repeat (LATENCY + 2) @(posedge clk_i);
  endtask

  task automatic write_reg(input reg_idx_e sel, input logic [15:0] val);
    @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= sel;
    cfg_data_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  row_t plan [] = '{
    '{ROW_SAMPLE, REG_KIND, 16'd0, 0},
    '{ROW_SAMPLE, REG_KIND, 16'd7, 0},
    '{ROW_SAMPLE, REG_KIND, 16'd5, NO_VALUE},
    '{ROW_SAMPLE, REG_KIND, 16'd8, 0},
    '{ROW_SAMPLE, REG_KIND, 16'hFFFF, 0},
    '{ROW_WRITE, REG_LENGTH, 16'd1, NO_VALUE},
    '{ROW_SAMPLE, REG_KIND, 16'd0, 32768},
    '{ROW_SAMPLE, REG_KIND, 16'd1, 0},
    '{ROW_WRITE, REG_LENGTH, 16'd0, NO_VALUE},
    '{ROW_SAMPLE, REG_KIND, 16'd0, 0},
    '{ROW_WRITE, REG_KIND, 16'd1, NO_VALUE},
    '{ROW_WRITE, REG_LENGTH, 16'd9, NO_VALUE},
    '{ROW_SAMPLE, REG_KIND, 16'd4, 32768},
    '{ROW_SAMPLE, REG_KIND, 16'd0, NO_VALUE},
    '{ROW_WRITE, REG_KIND, 16'd2, NO_VALUE},
    '{ROW_SAMPLE, REG_KIND, 16'd4, NO_VALUE},
    '{ROW_SAMPLE, REG_KIND, 16'd0, NO_VALUE},
    '{ROW_WRITE, REG_KIND, 16'd3, NO_VALUE},
    '{ROW_SAMPLE, REG_KIND, 16'd3, NO_VALUE},
    '{ROW_WRITE, REG_PERIODIC, 16'd1, NO_VALUE},
    '{ROW_WRITE, REG_LENGTH, 16'hFFFF, NO_VALUE},
    '{ROW_SAMPLE, REG_KIND, 16'd0, NO_VALUE},
    '{ROW_SAMPLE, REG_KIND, 16'd32768, NO_VALUE},
    '{ROW_SAMPLE, REG_KIND, 16'hFFFE, NO_VALUE},
    '{ROW_SAMPLE, REG_KIND, 16'hFFFF, 0}
  };

  initial begin
    int len, pick;
    logic [15:0] n;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    foreach (plan[r]) begin
      if (plan[r].kind == ROW_WRITE) begin
        settle();
        write_reg(plan[r].reg_sel, plan[r].value);
      end else begin
        forced_coef = plan[r].want_coef;
        send_index(plan[r].value);
        forced_coef = NO_VALUE;
      end
    end
    for (int ph = 0; ph < 8; ph++) begin
      settle();
      gaps_on = (ph < 6);
      pick = $urandom_range(0, 9);
      len = (pick == 0) ? 0 : (pick == 1) ? 1 : (pick == 2) ? 65535 :
            (pick == 3) ? $urandom_range(2, 65535) : $urandom_range(2, 64);
      write_reg(REG_KIND, 16'($urandom_range(0, 3)));
      write_reg(REG_LENGTH, 16'(len));
      write_reg(REG_PERIODIC, 16'($urandom_range(0, 1)));
      repeat (50) begin
        if (len > 0 && $urandom_range(0, 99) < 85) n = 16'($urandom_range(0, len - 1));
        else n = 16'($urandom_range(0, 65535));
        send_index(n);
      end
    end
    settle();
    $display("sent %0d index words over directed and 8 random window settings", words_taken);
    $display("checked %0d coefficient words, %0d mismatches", words_seen, errors);
    if (errors == 0 && pending_q.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

>>> sim.f
hdl/cwg_pkg.sv
hdl/cwg_div.sv
hdl/cwg_cos.sv
hdl/cwg_mix.sv
hdl/cosine_window_coefficient_generator.sv
tb/tb.sv
